// ===== sv/aise_pkg.sv =====
// Package for the array integer set engine: sizes, operation and status codes,
// FSM state type. Used by the channel interfaces, the core and the testbench.
package aise_pkg;

   localparam int CAPACITY = 16;                       // entries in the store
   localparam int IDX_W    = $clog2(CAPACITY);          // entry address
   localparam int CNT_W    = $clog2(CAPACITY + 1);      // count, 0..CAPACITY
   localparam int LIMIT_W  = 5;                         // capacity_limit register
   localparam int COUNT_W  = 5;                         // count field of a result
   localparam int DATA_W   = 32;
   localparam int CMP_W    = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

   typedef enum logic [1:0] {
      MODE_INSERT = 2'd0,
      MODE_REMOVE = 2'd1,
      MODE_TEST   = 2'd2,
      MODE_QUERY  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_FULL    = 2'd1,
      STATUS_NOMATCH = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

endpackage

// ===== sv/aise_if.sv =====
// Valid/ready channel interfaces for the set engine: request and response.
// Depends on aise_pkg for the field types.
interface aise_req_if import aise_pkg::*;;
   logic                     valid;
   logic                     ready;
   mode_type                 mode;
   logic signed [DATA_W-1:0] value;

   modport source (output valid, output mode, output value, input ready);
   modport sink   (input valid, input mode, input value, output ready);
endinterface

interface aise_rsp_if import aise_pkg::*;;
   logic                     valid;
   logic                     ready;
   status_type               status;
   logic                     found;
   logic [COUNT_W-1:0]       count;
   logic                     nonempty;
   logic signed [DATA_W-1:0] min_value;
   logic signed [DATA_W-1:0] max_value;

   modport source (output valid, output status, output found, output count,
                   output nonempty, output min_value, output max_value, input ready);
   modport sink   (input valid, input status, input found, input count,
                   input nonempty, input min_value, input max_value, output ready);
endinterface

// ===== sv/aise_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module aise_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/array_integer_set_engine_core.sv =====
// Array integer set engine core: unordered store of signed 32-bit values in a RAM.
// Depends on aise_pkg, aise_req_if / aise_rsp_if and aise_ram.
//
// A transaction passes from acceptance through the scan and finish states to a
// result in the output register. The scan is bound by the single RAM read port:
// it walks the stored entries one per cycle through a single equality and
// min/max compare unit, testing membership, compacting on remove (kept entries
// are written back at the write index) and tracking minimum and maximum; an
// insert appends in the finish state. A new request is taken only in idle, but
// may be taken while the previous result still waits in the output register.
// The capacity limit is clipped to the store size; a limit of zero rejects every
// insert.
module array_integer_set_engine_core import aise_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   aise_req_if.sink           req_if,
   aise_rsp_if.source         rsp_if,
   input  logic               csr_wr_en,
   input  logic [LIMIT_W-1:0] csr_wr_data
);

   state_type                state_ff, state_in;
   logic [LIMIT_W-1:0]       limit_ff;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic [CNT_W-1:0]         rd_ff, rd_in;
   logic [CNT_W-1:0]         wr_ff, wr_in;
   logic                     pend_ff, pend_in;
   logic                     found_ff, found_in;
   logic                     have_ff;
   logic signed [DATA_W-1:0] lo_ff, hi_ff;
   mode_type                 mode_ff;
   logic signed [DATA_W-1:0] val_ff;

   logic                     rsp_valid_ff;
   status_type               rsp_status_ff;
   logic                     rsp_found_ff;
   logic [CNT_W-1:0]         rsp_cnt_ff;
   logic signed [DATA_W-1:0] rsp_min_ff, rsp_max_ff;

   // RAM ports
   logic                     ram_wr_en;
   logic [IDX_W-1:0]         ram_wr_addr;
   logic [DATA_W-1:0]        ram_wr_data;
   logic [DATA_W-1:0]        ram_rd_data;

   // shared compare unit
   logic                     mm_en;
   logic signed [DATA_W-1:0] mm_x, lo_nx, hi_nx;
   logic                     have_nx;

   logic                     accept, out_free, scan_done, match, keep, full, ins_ok;
   logic [CNT_W-1:0]         final_cnt;
   status_type               final_status;

   aise_ram #(.WIDTH(DATA_W), .DEPTH(CAPACITY)) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (rd_ff[IDX_W-1:0]),
      .rd_data (ram_rd_data)
   );

   assign req_if.ready = (state_ff == ST_IDLE);
   assign accept       = req_if.valid && req_if.ready;
   assign out_free     = !rsp_valid_ff || rsp_if.ready;

   assign match     = pend_ff && (ram_rd_data == val_ff);
   assign keep      = pend_ff && !((mode_ff == MODE_REMOVE) && match);
   assign scan_done = (rd_ff == cnt_ff);

   // effective limit is min(capacity_limit, CAPACITY)
   assign full   = (CMP_W'(wr_ff) >= CMP_W'(limit_ff)) || (wr_ff == CNT_W'(CAPACITY));
   assign ins_ok = (mode_ff == MODE_INSERT) && !full;

   // min/max unit: kept entries during the scan, the inserted value at the end
   always_comb begin
      mm_x  = (state_ff == ST_SCAN) ? signed'(ram_rd_data) : val_ff;
      mm_en = (state_ff == ST_SCAN) ? keep : ins_ok;
      lo_nx   = lo_ff;
      hi_nx   = hi_ff;
      have_nx = have_ff;
      if (mm_en) begin
         have_nx = 1'b1;
         if (!have_ff || (mm_x < lo_ff)) begin
            lo_nx = mm_x;
         end
         if (!have_ff || (mm_x > hi_ff)) begin
            hi_nx = mm_x;
         end
      end
   end

   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = wr_ff[IDX_W-1:0];
      ram_wr_data = ram_rd_data;
      if (state_ff == ST_SCAN) begin
         ram_wr_en = keep && (mode_ff == MODE_REMOVE);
      end else if (state_ff == ST_FINISH) begin
         ram_wr_en   = ins_ok && out_free;
         ram_wr_data = val_ff;
      end
   end

   always_comb begin
      final_cnt    = ins_ok ? wr_ff + CNT_W'(1) : wr_ff;
      final_status = STATUS_OK;
      if ((mode_ff == MODE_INSERT) && full) begin
         final_status = STATUS_FULL;
      end else if ((mode_ff == MODE_REMOVE) && !found_ff) begin
         final_status = STATUS_NOMATCH;
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      rd_in    = rd_ff;
      wr_in    = wr_ff;
      pend_in  = 1'b0;
      found_in = found_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_SCAN;
               rd_in    = '0;
               wr_in    = '0;
               found_in = 1'b0;
            end
         end
         ST_SCAN: begin
            if (!scan_done) begin
               rd_in   = rd_ff + CNT_W'(1);
               pend_in = 1'b1;
            end
            if (match) begin
               found_in = 1'b1;
            end
            if (keep) begin
               wr_in = wr_ff + CNT_W'(1);
            end
            if (scan_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               cnt_in   = final_cnt;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         limit_ff     <= LIMIT_RESET;
         cnt_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         pend_ff  <= pend_in;
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
         if ((state_ff == ST_FINISH) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_ff    <= rd_in;
      wr_ff    <= wr_in;
      found_ff <= found_in;
      if (accept) begin
         mode_ff <= req_if.mode;
         val_ff  <= req_if.value;
         have_ff <= 1'b0;
      end else if (state_ff == ST_SCAN) begin
         have_ff <= have_nx;
         lo_ff   <= lo_nx;
         hi_ff   <= hi_nx;
      end
      if ((state_ff == ST_FINISH) && out_free) begin
         rsp_status_ff <= final_status;
         rsp_found_ff  <= found_ff;
         rsp_cnt_ff    <= final_cnt;
         rsp_min_ff    <= have_nx ? lo_nx : '0;
         rsp_max_ff    <= have_nx ? hi_nx : '0;
      end
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.status    = rsp_status_ff;
   assign rsp_if.found     = rsp_found_ff;
   assign rsp_if.count     = COUNT_W'(rsp_cnt_ff);
   assign rsp_if.nonempty  = (rsp_cnt_ff != '0);
   assign rsp_if.min_value = rsp_min_ff;
   assign rsp_if.max_value = rsp_max_ff;

endmodule

// ===== test/aise_set_checker.sv =====
// Set engine checker: watches the request, response and CSR ports, predicts each
// response with its own copy of the store, and counts mismatches.
// Depends on aise_pkg and the aise_req_if / aise_rsp_if interfaces.
module aise_set_checker import aise_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   aise_req_if                req_mon,
   aise_rsp_if                rsp_mon,
   input  logic               csr_wr_en,
   input  logic [LIMIT_W-1:0] csr_wr_data,
   output int                 fail_count,
   output int                 open_items
);

   typedef struct {
      status_type               status;
      logic                     found;
      logic [COUNT_W-1:0]       count;
      logic                     nonempty;
      logic signed [DATA_W-1:0] min_value;
      logic signed [DATA_W-1:0] max_value;
   } set_result_type;

   logic signed [DATA_W-1:0] set_entries [CAPACITY];
   int                       set_size;
   logic [LIMIT_W-1:0]       limit_reg;
   set_result_type           pending_results [$];

   // Applies one operation to the shadow store and returns the response it produces.
   function automatic set_result_type apply_set_op(mode_type op,
                                                   logic signed [DATA_W-1:0] v);
      set_result_type r;
      int             eff_limit;
      int             kept;
      r.found  = 1'b0;
      r.status = STATUS_OK;
      eff_limit = (limit_reg < CAPACITY) ? int'(limit_reg) : CAPACITY;
      for (int i = 0; i < set_size; i++)
         if (set_entries[i] == v) r.found = 1'b1;
      case (op)
         MODE_INSERT: begin
            if (set_size >= eff_limit) begin
               r.status = STATUS_FULL;
            end else begin
               set_entries[set_size] = v;
               set_size++;
            end
         end
         MODE_REMOVE: begin
            // compact: later entries slide down over every match
            kept = 0;
            for (int i = 0; i < set_size; i++) begin
               if (set_entries[i] != v) begin
                  set_entries[kept] = set_entries[i];
                  kept++;
               end
            end
            if (kept == set_size) r.status = STATUS_NOMATCH;
            set_size = kept;
         end
         default: ;
      endcase
      r.count     = set_size[COUNT_W-1:0];
      r.nonempty  = (set_size != 0);
      r.min_value = '0;
      r.max_value = '0;
      if (set_size > 0) begin
         r.min_value = set_entries[0];
         r.max_value = set_entries[0];
         for (int i = 1; i < set_size; i++) begin
            if (set_entries[i] < r.min_value) r.min_value = set_entries[i];
            if (set_entries[i] > r.max_value) r.max_value = set_entries[i];
         end
      end
      return r;
   endfunction

   function automatic int field_diff(string name, logic signed [63:0] expv,
                                     logic signed [63:0] actv);
      if (actv !== expv) begin
         $error("%s: expected %0d, got %0d", name, expv, actv);
         return 1;
      end
      return 0;
   endfunction

   always @(posedge clock) begin
      set_result_type exp_r;
      int             errs;
      errs = 0;
      if (reset) begin
         set_size  = 0;
         limit_reg = LIMIT_RESET;
         for (int i = 0; i < CAPACITY; i++) set_entries[i] = '0;
         pending_results.delete();
         fail_count <= 0;
      end else begin
         if (csr_wr_en) limit_reg = csr_wr_data;
         if (req_mon.valid && req_mon.ready)
            pending_results.push_back(apply_set_op(req_mon.mode, req_mon.value));
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (pending_results.size() == 0) begin
               $error("response transaction with no request outstanding");
               errs++;
            end else begin
               exp_r = pending_results.pop_front();
               errs += field_diff("status", exp_r.status, rsp_mon.status);
               errs += field_diff("found", exp_r.found, rsp_mon.found);
               errs += field_diff("count", exp_r.count, rsp_mon.count);
               errs += field_diff("nonempty", exp_r.nonempty, rsp_mon.nonempty);
               errs += field_diff("min_value", exp_r.min_value, rsp_mon.min_value);
               errs += field_diff("max_value", exp_r.max_value, rsp_mon.max_value);
            end
         end
         fail_count <= fail_count + errs;
      end
      open_items <= pending_results.size();
   end

endmodule

// ===== test/tb_array_integer_set_engine_core.sv =====
// Testbench top for array_integer_set_engine_core: clock, reset, request and
// response traffic with random gaps, capacity limit writes and the verdict.
// Depends on aise_pkg, the channel interfaces, the core and aise_set_checker.
module tb_array_integer_set_engine_core;
   import aise_pkg::*;

   localparam int DRAIN_CYCLES = 2 * (CAPACITY + 2) + 4;

   logic               clock = 1'b0;
   logic               reset;
   logic               csr_wr_en;
   logic [LIMIT_W-1:0] csr_wr_data;
   logic               quiet;
   int                 fail_count;
   int                 open_items;

   logic signed [DATA_W-1:0] value_pool [8];

   aise_req_if req_ch ();
   aise_rsp_if rsp_ch ();

   array_integer_set_engine_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_ch),
      .rsp_if      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   aise_set_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_ch),
      .rsp_mon     (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .fail_count  (fail_count),
      .open_items  (open_items)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Valid stays high across back-to-back transactions; it drops only for a gap.
   task automatic send_op(input mode_type op, input logic signed [DATA_W-1:0] v);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.mode  <= op;
      req_ch.value <= v;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (open_items != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_limit(input logic [LIMIT_W-1:0] lim);
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= lim;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   function automatic mode_type pick_mode();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return MODE_INSERT;
      if (r < 70) return MODE_REMOVE;
      if (r < 88) return MODE_TEST;
      return MODE_QUERY;
   endfunction

   // Mostly values from a small pool so removes and lookups hit stored entries.
   function automatic logic signed [DATA_W-1:0] pick_value();
      if ($urandom_range(0, 9) < 7) return value_pool[$urandom_range(0, 7)];
      return $urandom;
   endfunction

   task automatic run_random(input int n);
      for (int i = 0; i < n; i++) begin
         if (i % 20 == 0) quiet = ($urandom_range(0, 3) == 0);
         send_op(pick_mode(), pick_value());
      end
      quiet = 1'b0;
   endtask

   // response side: random stall before each transaction
   initial begin
      int stall;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = quiet ? 0 : $urandom_range(0, 8);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
      end
   end

   initial begin
      quiet        = 1'b0;
      reset        <= 1'b1;
      csr_wr_en    <= 1'b0;
      csr_wr_data  <= '0;
      req_ch.valid <= 1'b0;
      req_ch.mode  <= MODE_QUERY;
      req_ch.value <= '0;
      value_pool[0] = 32'sh8000_0000;
      value_pool[1] = 32'sh7fff_ffff;
      value_pool[2] = 0;
      value_pool[3] = -1;
      value_pool[4] = 1;
      for (int i = 5; i < 8; i++) value_pool[i] = $urandom;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // empty store: query, lookup and remove miss
      send_op(MODE_QUERY, 0);
      send_op(MODE_TEST, -1);
      send_op(MODE_REMOVE, 5);
      // extremes, duplicates, found on insert
      send_op(MODE_INSERT, 32'sh8000_0000);
      send_op(MODE_INSERT, 32'sh7fff_ffff);
      send_op(MODE_INSERT, 0);
      send_op(MODE_INSERT, -1);
      send_op(MODE_INSERT, 32'sh7fff_ffff);
      send_op(MODE_TEST, 32'sh7fff_ffff);
      send_op(MODE_TEST, 1);
      send_op(MODE_REMOVE, 32'sh7fff_ffff);
      send_op(MODE_INSERT, 0);
      send_op(MODE_REMOVE, 7);
      send_op(MODE_QUERY, 0);
      send_op(MODE_REMOVE, 32'sh8000_0000);
      run_random(120);

      write_limit(5'd0);
      send_op(MODE_INSERT, 42);
      run_random(40);
      write_limit(5'd31);
      run_random(120);
      write_limit(5'd2);
      run_random(60);
      write_limit(5'd1);
      run_random(40);
      write_limit(LIMIT_RESET);
      run_random(120);
      write_limit(LIMIT_W'($urandom_range(3, 15)));
      run_random(60);
      write_limit(LIMIT_W'($urandom_range(17, 30)));
      run_random(60);

      wait_drained();
      if (fail_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      #2000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
